// ===== src/lbct_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU block cache tags package
// Types and constants shared by the tag and replacement engine.
// ----------------------------------------------------------------------------
package lbct_pkg;

	localparam int ENTRIES    = 64;
	localparam int BLOCK_BITS = 32;
	localparam int SLOT_BITS  = $clog2(ENTRIES);

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_NOT_FOUND = 1'b1;

	typedef struct packed {
		logic                  operation;
		logic [BLOCK_BITS-1:0] block_number;
	} lbct_req_t;

	typedef struct packed {
		logic                  status;
		logic                  hit;
		logic [SLOT_BITS-1:0]  slot;
		logic                  evict_valid;
		logic                  evict_dirty;
		logic [BLOCK_BITS-1:0] evict_block;
	} lbct_rsp_t;

endpackage

// ===== src/lru_block_cache_tags_top.sv =====
// ----------------------------------------------------------------------------
// LRU block cache tags
// Fully associative tag store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A request accepted with start is held in the request register, and its result
// is captured in the result register, where done and rsp show it on the ports.
// Throughput: one request per cycle; busy stays low and results cannot stall.
// The tag compare, rank update and victim choice are one combinational pass
// between the request register and the result register.
// Reset clears all tags, valid and dirty flags; entry i gets rank i.
module lru_block_cache_tags_top
	import lbct_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  lbct_req_t req,
	output logic      done,
	output lbct_rsp_t rsp
);

	lbct_req_t             req_s1;
	logic                  valid_s1;

	logic [BLOCK_BITS-1:0] tag_q   [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;
	logic [ENTRIES-1:0]    dirty_q;
	logic [SLOT_BITS-1:0]  rank_q  [ENTRIES];

	logic [ENTRIES-1:0]    match;
	logic [ENTRIES-1:0]    victim_oh;
	logic [ENTRIES-1:0]    target_oh;
	logic [SLOT_BITS-1:0]  hit_idx;
	logic [SLOT_BITS-1:0]  victim_idx;
	logic [SLOT_BITS-1:0]  target_rank;
	logic [BLOCK_BITS-1:0] victim_tag;
	logic                  victim_valid;
	logic                  victim_dirty;
	logic                  found;
	logic                  is_write;
	logic                  do_update;
	lbct_rsp_t             rsp_next;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_s1 <= req;
		end
	end

	// Valid tags are unique and ranks form a permutation, so one-hot
	// vectors can be encoded by OR-ing the indices.
	always_comb begin
		hit_idx      = '0;
		victim_idx   = '0;
		target_rank  = '0;
		victim_tag   = '0;
		victim_valid = 1'b0;
		victim_dirty = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]     = valid_q[i] && (tag_q[i] == req_s1.block_number);
			victim_oh[i] = (rank_q[i] == SLOT_BITS'(ENTRIES - 1));
		end
		found     = |match;
		is_write  = (req_s1.operation == OP_WRITE);
		target_oh = found ? match : victim_oh;
		do_update = valid_s1 && (found || is_write);
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				hit_idx = hit_idx | SLOT_BITS'(i);
			end
			if (victim_oh[i]) begin
				victim_idx   = victim_idx | SLOT_BITS'(i);
				victim_tag   = victim_tag | tag_q[i];
				victim_valid = victim_valid | valid_q[i];
				victim_dirty = victim_dirty | dirty_q[i];
			end
			if (target_oh[i]) begin
				target_rank = target_rank | rank_q[i];
			end
		end
	end

	always_comb begin
		rsp_next = '0;
		if (found) begin
			rsp_next.status = STATUS_OK;
			rsp_next.hit    = 1'b1;
			rsp_next.slot   = hit_idx;
		end else if (!is_write) begin
			rsp_next.status = STATUS_NOT_FOUND;
		end else begin
			rsp_next.status      = STATUS_OK;
			rsp_next.slot        = victim_idx;
			rsp_next.evict_valid = victim_valid;
			rsp_next.evict_dirty = victim_dirty;
			rsp_next.evict_block = victim_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				tag_q[i]  <= '0;
				rank_q[i] <= SLOT_BITS'(i);
			end
		end else if (do_update) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (target_oh[i]) begin
					rank_q[i] <= '0;
					if (is_write) begin
						dirty_q[i] <= 1'b1;
					end
					if (!found) begin
						valid_q[i] <= 1'b1;
						tag_q[i]   <= req_s1.block_number;
					end
				end else if (rank_q[i] < target_rank) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp <= rsp_next;
		end
	end

	// The ranks must stay a permutation: exactly one entry is least recent.
	a_one_victim: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(victim_oh))
		else $error("recency ranks lost their permutation");

	// Valid tags must stay unique.
	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("block number matched more than one entry");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == STATUS_NOT_FOUND) |->
			!rsp.hit && (rsp.slot == '0) && !rsp.evict_valid && !rsp.evict_dirty)
		else $error("read miss result carries stray fields");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.hit |-> (rsp.status == STATUS_OK) && !rsp.evict_valid
			&& !rsp.evict_dirty && (rsp.evict_block == '0))
		else $error("hit result reports an eviction");

endmodule
